>>> design/ssi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants of the segment crossing test.
// ----------------------------------------------------------------------------
package ssi_pkg;

	localparam int DIR_FRAC   = 14;
	localparam int QBITS      = 31;
	localparam int DIV_STEPS  = QBITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

	localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

	typedef enum logic [2:0] {
		REG_POS_X   = 3'd0,
		REG_POS_Y   = 3'd1,
		REG_POS_Z   = 3'd2,
		REG_DIR_X   = 3'd3,
		REG_DIR_Y   = 3'd4,
		REG_DIR_Z   = 3'd5,
		REG_LENGTH  = 3'd6,
		REG_TOL     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [15:0] dir_x;
		logic [15:0] dir_y;
		logic [15:0] dir_z;
		logic [30:0] length;
		logic [28:0] tol;
	} cfg_t;

	// Classified request handed from the front to the back
	typedef struct packed {
		logic        miss;
		logic [32:0] denom;
		logic [49:0] ns;
		logic [49:0] nt;
		logic [30:0] seg_len;
	} work_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} res_t;

endpackage

>>> design/ssi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_front
// Three-stage front: direction dot product, parallel test, denominator and
// the two perp-dot numerators.
// ----------------------------------------------------------------------------
module ssi_front
	import ssi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        push,
	output logic        full,
	input  logic [31:0] seg_pos_x,
	input  logic [31:0] seg_pos_y,
	input  logic [15:0] seg_dir_x,
	input  logic [15:0] seg_dir_y,
	input  logic [15:0] seg_dir_z,
	input  logic [30:0] seg_length,
	input  logic        q_full,
	output logic        q_push,
	output work_t       q_data
);

	logic en;
	logic v_s1, v_s2, v_s3;

	logic signed [31:0] pdx_s1, pdy_s1, pdz_s1, pda_s1, pdb_s1;
	logic signed [32:0] wx_s1, wy_s1;
	logic signed [15:0] bdx_s1, bdy_s1;
	logic [30:0]        len_s1;

	logic               miss_s2;
	logic signed [32:0] den_s2;
	logic signed [48:0] m1_s2, m2_s2, m3_s2, m4_s2;
	logic [30:0]        len_s2;

	work_t              work_s3;

	logic signed [35:0] dot;
	logic signed [35:0] tol36;
	logic               par;

	assign en     = !v_s3 || !q_full;
	assign full   = !en;
	assign q_push = v_s3 && !q_full;
	assign q_data = work_s3;

	assign dot = 36'(pdx_s1) + 36'(pdy_s1) + 36'(pdz_s1);
	assign tol36 = $signed({7'b0, cfg.tol});
	assign par = (dot >= ONE_Q28 - tol36 && dot <= ONE_Q28 + tol36) ||
		(dot >= -ONE_Q28 - tol36 && dot <= -ONE_Q28 + tol36);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pdx_s1 <= $signed(cfg.dir_x) * $signed(seg_dir_x);
			pdy_s1 <= $signed(cfg.dir_y) * $signed(seg_dir_y);
			pdz_s1 <= $signed(cfg.dir_z) * $signed(seg_dir_z);
			pda_s1 <= $signed(cfg.dir_y) * $signed(seg_dir_x);
			pdb_s1 <= $signed(cfg.dir_x) * $signed(seg_dir_y);
			wx_s1  <= $signed({cfg.pos_x[31], cfg.pos_x}) - $signed({seg_pos_x[31], seg_pos_x});
			wy_s1  <= $signed({cfg.pos_y[31], cfg.pos_y}) - $signed({seg_pos_y[31], seg_pos_y});
			bdx_s1 <= $signed(seg_dir_x);
			bdy_s1 <= $signed(seg_dir_y);
			len_s1 <= seg_length;

			miss_s2 <= par;
			den_s2  <= 33'(pdb_s1) - 33'(pda_s1);
			m1_s2   <= $signed(cfg.dir_y) * wx_s1;
			m2_s2   <= $signed(cfg.dir_x) * wy_s1;
			m3_s2   <= bdy_s1 * wx_s1;
			m4_s2   <= bdx_s1 * wy_s1;
			len_s2  <= len_s1;

			work_s3.miss    <= miss_s2 || (den_s2 == 33'sd0);
			work_s3.denom   <= den_s2;
			work_s3.ns      <= 50'(m2_s2) - 50'(m1_s2);
			work_s3.nt      <= 50'(m4_s2) - 50'(m3_s2);
			work_s3.seg_len <= len_s2;
		end
	end

endmodule

>>> design/ssi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module ssi_queue
	import ssi_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  work_t wr_data,
	output logic  full_o,
	output logic  valid,
	output work_t rd_data,
	input  logic  rd
);

	work_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

endmodule

>>> design/ssi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_back
// Back pipeline: two restoring dividers of one bit per stage, range checks,
// crossing point with rounding and saturation, result register.
// ----------------------------------------------------------------------------
module ssi_back
	import ssi_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  work_t q_data,
	output logic  q_pop,
	output res_t  res,
	output logic  empty,
	input  logic  pop
);

	typedef struct packed {
		logic        miss;
		logic [30:0] seg_len;
		logic [31:0] magd;
		logic        neg_s, neg_t;
		logic [63:0] magn_s, magn_t;
	} abs_t;

	typedef struct packed {
		logic        miss;
		logic [30:0] seg_len;
		logic [31:0] magd;
		logic        neg_s, neg_t, ovf_s, ovf_t;
		logic [31:0] rem_s, rem_t;
		logic [30:0] lo_s, lo_t;
		logic [30:0] q_s, q_t;
	} div_t;

	function automatic void div_step(input logic [31:0] rem, input logic [30:0] lo,
		input logic [30:0] q, input logic [31:0] d, output logic [31:0] rem_o,
		output logic [30:0] lo_o, output logic [30:0] q_o);
		logic [32:0] sh;
		sh = {rem, lo[30]};
		lo_o = {lo[29:0], 1'b0};
		if (sh >= {1'b0, d}) begin
			rem_o = 32'(sh - {1'b0, d});
			q_o = {q[29:0], 1'b1};
		end else begin
			rem_o = sh[31:0];
			q_o = {q[29:0], 1'b0};
		end
	endfunction

	logic adv;
	logic v_s1;
	logic v_div [DIV_STEPS+1];
	logic v_s34, v_s35;

	abs_t abs_s1;
	div_t div_s [DIV_STEPS+1];  // stages 2 .. 33

	logic               hit_s34;
	logic signed [47:0] px_s34, py_s34, pz_s34;
	res_t               res_s35;

	logic [49:0] mag_ns, mag_nt;
	logic [32:0] top_s, top_t;
	div_t        last;
	logic        pass_s, pass_t;
	logic [30:0] t_val;
	logic signed [31:0] t_sg;

	assign adv   = !v_s35 || pop;
	assign q_pop = q_valid && adv;
	assign empty = !v_s35;
	assign res   = res_s35;

	assign mag_ns = q_data.ns[49] ? 50'(-q_data.ns) : q_data.ns;
	assign mag_nt = q_data.nt[49] ? 50'(-q_data.nt) : q_data.nt;
	assign top_s  = abs_s1.magn_s[63:31];
	assign top_t  = abs_s1.magn_t[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
		end else if (adv) begin
			v_s1  <= q_valid;
			v_s34 <= v_div[DIV_STEPS];
			v_s35 <= v_s34;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_div[0] <= 1'b0;
		else if (adv)
			v_div[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			abs_s1.miss    <= q_data.miss;
			abs_s1.seg_len <= q_data.seg_len;
			abs_s1.magd    <= q_data.denom[32] ? 32'(-q_data.denom) : q_data.denom[31:0];
			abs_s1.neg_s   <= q_data.ns[49] ^ q_data.denom[32];
			abs_s1.neg_t   <= q_data.nt[49] ^ q_data.denom[32];
			abs_s1.magn_s  <= {mag_ns[49:0], 14'b0};
			abs_s1.magn_t  <= {mag_nt[49:0], 14'b0};

			// quotient of 2^31 or more never passes the range test
			div_s[0].miss    <= abs_s1.miss;
			div_s[0].seg_len <= abs_s1.seg_len;
			div_s[0].magd    <= abs_s1.magd;
			div_s[0].neg_s   <= abs_s1.neg_s;
			div_s[0].neg_t   <= abs_s1.neg_t;
			div_s[0].ovf_s   <= top_s >= {1'b0, abs_s1.magd};
			div_s[0].ovf_t   <= top_t >= {1'b0, abs_s1.magd};
			div_s[0].rem_s   <= top_s[31:0];
			div_s[0].rem_t   <= top_t[31:0];
			div_s[0].lo_s    <= abs_s1.magn_s[30:0];
			div_s[0].lo_t    <= abs_s1.magn_t[30:0];
			div_s[0].q_s     <= '0;
			div_s[0].q_t     <= '0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_div[k+1] <= 1'b0;
			else if (adv)
				v_div[k+1] <= v_div[k];
		end

		always_ff @(posedge clk) begin
			logic [31:0] rs, rt;
			logic [30:0] ls, lt, qs, qt;
			div_t        nx;
			if (adv) begin
				div_step(div_s[k].rem_s, div_s[k].lo_s, div_s[k].q_s, div_s[k].magd, rs, ls, qs);
				div_step(div_s[k].rem_t, div_s[k].lo_t, div_s[k].q_t, div_s[k].magd, rt, lt, qt);
				nx       = div_s[k];
				nx.rem_s = rs;
				nx.lo_s  = ls;
				nx.q_s   = qs;
				nx.rem_t = rt;
				nx.lo_t  = lt;
				nx.q_t   = qt;
				div_s[k+1] <= nx;
			end
		end
	end

	assign last = div_s[DIV_STEPS];
	// a negative quotient that truncates to zero counts as zero
	assign pass_s = !last.ovf_s && (last.neg_s ? (last.q_s == '0) : (last.q_s <= last.seg_len));
	assign pass_t = !last.ovf_t && (last.neg_t ? (last.q_t == '0) : (last.q_t <= cfg.length));
	assign t_val  = last.neg_t ? '0 : last.q_t;
	assign t_sg   = $signed({1'b0, t_val});

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s34 <= !last.miss && pass_s && pass_t;
			px_s34  <= $signed(cfg.dir_x) * t_sg;
			py_s34  <= $signed(cfg.dir_y) * t_sg;
			pz_s34  <= $signed(cfg.dir_z) * t_sg;

			res_s35.hit <= hit_s34;
			res_s35.x   <= hit_s34 ? place(cfg.pos_x, px_s34) : '0;
			res_s35.y   <= hit_s34 ? place(cfg.pos_y, py_s34) : '0;
			res_s35.z   <= hit_s34 ? place(cfg.pos_z, pz_s34) : '0;
		end
	end

	// base + round(p / 2^14), halves up, saturated to 32 bits
	function automatic logic [31:0] place(input logic [31:0] base, input logic signed [47:0] p);
		logic signed [48:0] rp;
		logic signed [35:0] sum;
		rp  = 49'(p) + 49'sd8192;
		sum = 36'($signed(base)) + 36'($signed(rp[48:DIR_FRAC]));
		if (sum > 36'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (sum < -36'sd2147483648)
			return 32'h8000_0000;
		else
			return sum[31:0];
	endfunction

endmodule

>>> design/segment_segment_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_intersect
// Tests streamed segments against one reference segment held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   Write the reference segment and tolerance through cfg_we/cfg_index/
//   cfg_data while the block is idle. Push one tested segment per cycle with
//   push while full is low. Each request gives exactly one result, in order,
//   on hit/cross_x/cross_y/cross_z while empty is low; take it with pop.
//   Requests pass through three front stages, the request queue and a
//   35-stage back pipeline holding two one-bit-per-stage dividers; one
//   request is taken per cycle while full is low. When a result is waiting
//   and pop stays low the back pipeline holds; the four-entry queue and the
//   three front stages keep taking requests until they fill, then full rises.
//   Reset clears the pipeline valid flags and queue pointers and loads the
//   reference registers with a unit X segment at the origin, length 65536.
// ----------------------------------------------------------------------------
module segment_segment_intersect
	import ssi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [31:0] seg_pos_x,
	input  logic [31:0] seg_pos_y,
	input  logic [15:0] seg_dir_x,
	input  logic [15:0] seg_dir_y,
	input  logic [15:0] seg_dir_z,
	input  logic [30:0] seg_length,
	output logic        empty,
	input  logic        pop,
	output logic        hit,
	output logic [31:0] cross_x,
	output logic [31:0] cross_y,
	output logic [31:0] cross_z
);

	cfg_t  cfg_q;
	logic  q_push, q_full, q_valid, q_pop;
	work_t q_wdata, q_rdata;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x  <= '0;
			cfg_q.pos_y  <= '0;
			cfg_q.pos_z  <= '0;
			cfg_q.dir_x  <= 16'd16384;
			cfg_q.dir_y  <= '0;
			cfg_q.dir_z  <= '0;
			cfg_q.length <= 31'd65536;
			cfg_q.tol    <= 29'd16;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_POS_X:  cfg_q.pos_x  <= cfg_data;
				REG_POS_Y:  cfg_q.pos_y  <= cfg_data;
				REG_POS_Z:  cfg_q.pos_z  <= cfg_data;
				REG_DIR_X:  cfg_q.dir_x  <= cfg_data[15:0];
				REG_DIR_Y:  cfg_q.dir_y  <= cfg_data[15:0];
				REG_DIR_Z:  cfg_q.dir_z  <= cfg_data[15:0];
				REG_LENGTH: cfg_q.length <= cfg_data[30:0];
				REG_TOL:    cfg_q.tol    <= cfg_data[28:0];
				default: ;
			endcase
		end
	end

	ssi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.seg_pos_x  (seg_pos_x),
		.seg_pos_y  (seg_pos_y),
		.seg_dir_x  (seg_dir_x),
		.seg_dir_y  (seg_dir_y),
		.seg_dir_z  (seg_dir_z),
		.seg_length (seg_length),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	ssi_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_wdata),
		.full_o  (q_full),
		.valid   (q_valid),
		.rd_data (q_rdata),
		.rd      (q_pop)
	);

	ssi_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.res     (res),
		.empty   (empty),
		.pop     (pop)
	);

	assign hit     = res.hit;
	assign cross_x = res.x;
	assign cross_y = res.y;
	assign cross_z = res.z;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("request pushed into full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("request popped from empty queue");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !hit) |-> (cross_x == '0 && cross_y == '0 && cross_z == '0))
		else $error("miss result carries a nonzero point");

endmodule
